// ===== rtl/core/itoaf_pkg.sv =====
// ----------------------------------------------------------------------------
// itoaf_pkg
// Shared types and constants of the integer to ascii formatter.
// ----------------------------------------------------------------------------
package itoaf_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int DIGIT_SLOTS_DEF = 16;
	localparam int ITEM_VALUE_W    = 32;

	// kind codes: zero is signed decimal, any other selects hex
	localparam logic [1:0] KIND_DEC       = 2'd0;
	localparam logic [1:0] KIND_HEX_LOWER = 2'd1;
	localparam logic [1:0] KIND_HEX_UPPER = 2'd2;
	localparam int         KIND_UPPER_BIT = 1;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_MINUS   = 8'h2d;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [3:0] DIGIT_MASK   = 4'hf;

	typedef struct packed {
		logic [1:0]              kind;
		logic [ITEM_VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} result_t;

	typedef struct packed {
		logic hex;
		logic upper;
		logic neg;
	} job_flags_t;

endpackage

// ===== rtl/core/itoaf_classify.sv =====
// ----------------------------------------------------------------------------
// itoaf_classify
// Decodes the kind of an incoming word and forms sign and magnitude.
// ----------------------------------------------------------------------------
module itoaf_classify #(
	parameter int VW = itoaf_pkg::VALUE_WIDTH_DEF
) (
	input  itoaf_pkg::item_t      item,
	output itoaf_pkg::job_flags_t flags,
	output logic [VW-1:0]         mag
);
	import itoaf_pkg::*;

	logic [VW-1:0] raw;

	// only the low VW bits take part, zero filled above the item width
	assign raw = VW'(item.value);

	always_comb begin
		flags.hex   = (item.kind != KIND_DEC);
		flags.upper = item.kind[KIND_UPPER_BIT];
		flags.neg   = (item.kind == KIND_DEC) && raw[VW-1];
		// most negative value comes out as its unsigned magnitude
		mag         = flags.neg ? (~raw + VW'(1)) : raw;
	end

endmodule

// ===== rtl/core/itoaf_queue.sv =====
// ----------------------------------------------------------------------------
// itoaf_queue
// Two-entry job queue between the classify front and the conversion back.
// ----------------------------------------------------------------------------
module itoaf_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output logic          full,
	output logic          empty
);
	import itoaf_pkg::*;

	logic [DW-1:0] entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/core/itoaf_back.sv =====
// ----------------------------------------------------------------------------
// itoaf_back
// Turns a queued magnitude into digits (shift-add-3 for decimal, nibble
// shift for hex) and emits the characters most significant first.
// ----------------------------------------------------------------------------
module itoaf_back #(
	parameter int VW    = itoaf_pkg::VALUE_WIDTH_DEF,
	parameter int SLOTS = itoaf_pkg::DIGIT_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	input  itoaf_pkg::job_flags_t job_flags,
	input  logic [VW-1:0]         job_mag,
	output logic                  job_pop,
	output itoaf_pkg::result_t    result,
	output logic                  strobe
);
	import itoaf_pkg::*;

	localparam int PAD_W     = ((VW + 3) / 4) * 4;
	localparam int DEC_STEPS = PAD_W / 2;
	localparam int HEX_STEPS = PAD_W / 4;
	localparam int STEP_W    = $clog2(DEC_STEPS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic hex,
		input logic upper);
		logic [7:0] base;
		base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
		if (hex && (d >= 4'd10))
			return base + 8'(d - 4'd10);
		return CHAR_ZERO + 8'(d & DIGIT_MASK);
	endfunction

	state_t                 state_q;
	logic [PAD_W-1:0]       bits_q;
	logic [SLOTS-1:0][3:0]  digits_q;
	logic [SLOTS:0]         top_q;
	logic [SLOTS-1:0]       emit_q;
	logic [STEP_W-1:0]      steps_q;
	job_flags_t             flags_q;
	result_t                result_q;
	logic                   strobe_q;

	logic [SLOTS-1:0][3:0]  adj1, sh1, adj2, sh2, hex_digits, digits_step;
	logic [PAD_W-1:0]       bits_step;
	logic [SLOTS-1:0]       nz;
	logic [SLOTS:0]         top_step;
	logic [SLOTS-1:0]       emit_next;
	logic [3:0]             sel_digit;

	// one conversion step: two dabble bits for decimal, one nibble for hex
	always_comb begin
		for (int i = 0; i < SLOTS; i++)
			adj1[i] = (digits_q[i] >= 4'd5) ? digits_q[i] + 4'd3 : digits_q[i];
		sh1[0] = {adj1[0][2:0], bits_q[PAD_W-1]};
		for (int i = 1; i < SLOTS; i++)
			sh1[i] = {adj1[i][2:0], adj1[i-1][3]};
		for (int i = 0; i < SLOTS; i++)
			adj2[i] = (sh1[i] >= 4'd5) ? sh1[i] + 4'd3 : sh1[i];
		sh2[0] = {adj2[0][2:0], bits_q[PAD_W-2]};
		for (int i = 1; i < SLOTS; i++)
			sh2[i] = {adj2[i][2:0], adj2[i-1][3]};

		hex_digits[0] = bits_q[PAD_W-1 -: 4];
		for (int i = 1; i < SLOTS; i++)
			hex_digits[i] = digits_q[i-1];

		digits_step = flags_q.hex ? hex_digits : sh2;
		bits_step   = flags_q.hex ? (bits_q << 4) : (bits_q << 2);

		for (int i = 0; i < SLOTS; i++)
			nz[i] = (digits_step[i] != 4'd0);
		// the digit count grows by at most one per step
		top_step  = (|(nz & top_q[SLOTS-1:0])) ? (top_q << 1) : top_q;
		emit_next = top_step[0] ? SLOTS'(1) : top_step[SLOTS:1];

		sel_digit = 4'd0;
		for (int i = 0; i < SLOTS; i++)
			sel_digit = sel_digit | (emit_q[i] ? digits_q[i] : 4'd0);
	end

	assign job_pop = (state_q == ST_IDLE) && job_valid;
	assign result  = result_q;
	assign strobe  = strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			steps_q  <= '0;
			top_q    <= '0;
			emit_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						top_q   <= (SLOTS + 1)'(1);
						steps_q <= job_flags.hex ? STEP_W'(HEX_STEPS) : STEP_W'(DEC_STEPS);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					top_q   <= top_step;
					steps_q <= steps_q - STEP_W'(1);
					if (steps_q == STEP_W'(1)) begin
						emit_q  <= emit_next;
						state_q <= flags_q.neg ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					emit_q   <= emit_q >> 1;
					if (emit_q[0])
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bits_q   <= PAD_W'(job_mag);
				digits_q <= '0;
				flags_q  <= job_flags;
			end
			ST_CONV: begin
				bits_q   <= bits_step;
				digits_q <= digits_step;
			end
			ST_SIGN: begin
				result_q <= '{out_char: CHAR_MINUS, last: 1'b0};
			end
			ST_EMIT: begin
				result_q <= '{out_char: digit_char(sel_digit, flags_q.hex, flags_q.upper),
					last: emit_q[0]};
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/integer_to_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Converts a value to decimal or hex ascii, one character per strobe.
// ----------------------------------------------------------------------------
// an accepted word waits in a two-entry queue; busy is high only when it is full
// per word: a dispatch from idle, the digit steps (shift-add-3 for decimal, nibble shift
// for hex), a minus sign for a negative decimal value, then the digits most significant first
// reset empties the queue and returns the converter to idle; results are never stalled
module integer_to_ascii_formatter_unit #(
	parameter int VALUE_WIDTH = itoaf_pkg::VALUE_WIDTH_DEF,
	parameter int DIGIT_SLOTS = itoaf_pkg::DIGIT_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  itoaf_pkg::item_t   item,
	output itoaf_pkg::result_t result,
	output logic               strobe
);
	import itoaf_pkg::*;

	localparam int JOB_W = VALUE_WIDTH + $bits(job_flags_t);

	job_flags_t             in_flags;
	logic [VALUE_WIDTH-1:0] in_mag;
	logic [JOB_W-1:0]       head_job;
	job_flags_t             head_flags;
	logic [VALUE_WIDTH-1:0] head_mag;
	logic                   push;
	logic                   pop;
	logic                   q_empty;

	assign push = start && !busy;
	assign {head_flags, head_mag} = head_job;

	itoaf_classify #(
		.VW (VALUE_WIDTH)
	) u_classify (
		.item  (item),
		.flags (in_flags),
		.mag   (in_mag)
	);

	itoaf_queue #(
		.DW (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({in_flags, in_mag}),
		.pop       (pop),
		.pop_data  (head_job),
		.full      (busy),
		.empty     (q_empty)
	);

	itoaf_back #(
		.VW    (VALUE_WIDTH),
		.SLOTS (DIGIT_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job_flags (head_flags),
		.job_mag   (head_mag),
		.job_pop   (pop),
		.result    (result),
		.strobe    (strobe)
	);

endmodule

// ===== verif/integer_to_ascii_formatter_unit_test.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit_test
// Drives words of kind and value into the formatter and checks every emitted
// character and its last flag against the table text or a local model.
// A table of directed words comes first, then a few hundred random words.
// Random gaps on the start side vary the phase of a conversion at which a word arrives.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	import itoaf_pkg::*;

	localparam int         RANDOM_WORDS  = 500;
	localparam int         DIRECTED_ROWS = 19;
	localparam int         DRAIN_CYCLES  = 40;
	// kind three: both bits set, behaves as upper-case hex
	localparam logic [1:0] KIND_HEX_ALT  = KIND_HEX_LOWER | KIND_HEX_UPPER;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	result_t result;
	logic    strobe;

	result_t     pending_chars[$];
	logic [3:0]  digit_buf[16];
	int          digit_total;
	bit          neg_flag;
	int          words_sent;
	int          chars_checked;
	int          error_count;
	int          kind_seen[4];
	int          quiet_left;

	integer_to_ascii_formatter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.result (result),
		.strobe (strobe)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// directed words; empty text means the model supplies the characters
	item_t vec_item[DIRECTED_ROWS] = '{
		'{KIND_DEC,       32'h0000_0000},
		'{KIND_DEC,       32'h0000_0009},
		'{KIND_DEC,       32'h0000_000a},
		'{KIND_DEC,       32'h7fff_ffff},
		'{KIND_DEC,       32'h8000_0000},
		'{KIND_DEC,       32'hffff_ffff},
		'{KIND_DEC,       32'h3b9a_ca00},
		'{KIND_DEC,       32'hc465_3600},
		'{KIND_DEC,       32'hffff_fff6},
		'{KIND_HEX_LOWER, 32'h0000_0000},
		'{KIND_HEX_LOWER, 32'hffff_ffff},
		'{KIND_HEX_UPPER, 32'hffff_ffff},
		'{KIND_HEX_LOWER, 32'h0000_000f},
		'{KIND_HEX_UPPER, 32'h0000_0010},
		'{KIND_HEX_LOWER, 32'h8000_0000},
		'{KIND_HEX_ALT,   32'habcd_ef09},
		'{KIND_HEX_ALT,   32'h0000_0000},
		'{KIND_DEC,       32'h1234_5678},
		'{KIND_HEX_LOWER, 32'h0bad_cafe}
	};

	string vec_text[DIRECTED_ROWS] = '{
		"0", "9", "10", "2147483647", "-2147483648", "-1", "1000000000",
		"-1000000000", "-10", "0", "ffffffff", "FFFFFFFF", "f", "10",
		"80000000", "ABCDEF09", "0", "", ""
	};

	function automatic logic [7:0] digit_ascii(logic [3:0] d, bit hex, bit upper);
		if (d < 4'd10 || !hex)
			return CHAR_ZERO + {4'd0, d};
		return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'd0, d} - 8'd10;
	endfunction

	// splits the value into digits and queues the characters it should produce
	function automatic void format_chars(item_t w);
		logic [31:0] mag;
		bit          hex;
		bit          upper;
		result_t     r;

		hex   = w.kind != KIND_DEC;
		upper = w.kind[KIND_UPPER_BIT];
		mag   = w.value;
		neg_flag = !hex && mag[31];
		// unsigned negate keeps the most negative value intact
		if (neg_flag)
			mag = ~mag + 32'd1;
		digit_total = 0;
		do begin
			if (hex) begin
				digit_buf[digit_total] = mag[3:0];
				mag = mag >> 4;
			end else begin
				digit_buf[digit_total] = 4'(mag % 32'd10);
				mag = mag / 32'd10;
			end
			digit_total++;
		end while (mag != 0 && digit_total < DIGIT_SLOTS_DEF);
		if (neg_flag) begin
			r.out_char = CHAR_MINUS;
			r.last     = 1'b0;
			pending_chars.push_back(r);
		end
		for (int k = digit_total - 1; k >= 0; k--) begin
			r.out_char = digit_ascii(digit_buf[k], hex, upper);
			r.last     = (k == 0);
			pending_chars.push_back(r);
		end
	endfunction

	function automatic void queue_text(string text);
		result_t r;

		for (int i = 0; i < text.len(); i++) begin
			r.out_char = text[i];
			r.last     = (i == text.len() - 1);
			pending_chars.push_back(r);
		end
	endfunction

	// mostly short gaps, a few long ones, and runs with none at all
	function automatic int pick_gap();
		int r;

		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet_left = $urandom_range(8, 30);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// holds start high until the word is taken, then drops it for a random gap, if any
	task automatic issue_word(item_t w, string text);
		int gap;

		item  <= w;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		if (text.len() != 0)
			queue_text(text);
		else
			format_chars(w);
		words_sent++;
		kind_seen[w.kind]++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] random_value();
		logic [31:0] v;

		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2:    v = $urandom_range(0, 99);
			3:    v = $urandom >> $urandom_range(0, 31);
			4:    v = -$urandom_range(1, 1000);
			default: begin
				// around a power of ten, either sign
				v = 32'd1;
				repeat ($urandom_range(0, 9)) v = v * 32'd10;
				v = v + $urandom_range(0, 2) - 32'd1;
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [1:0] random_kind();
		int r;

		r = $urandom_range(0, 9);
		if (r < 4)
			return KIND_DEC;
		if (r < 7)
			return KIND_HEX_LOWER;
		if (r < 9)
			return KIND_HEX_UPPER;
		return KIND_HEX_ALT;
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected char: expected none, actual %h last %b",
					$time, result.out_char, result.last);
				error_count++;
			end else begin
				if (result.out_char !== pending_chars[0].out_char) begin
					$display("%0t: char mismatch: expected %h, actual %h",
						$time, pending_chars[0].out_char, result.out_char);
					error_count++;
				end
				if (result.last !== pending_chars[0].last) begin
					$display("%0t: last mismatch: expected %b, actual %b",
						$time, pending_chars[0].last, result.last);
					error_count++;
				end
				void'(pending_chars.pop_front());
				chars_checked++;
			end
		end
	end

	initial begin
		item_t w;

		arst_n        = 1'b0;
		start         = 1'b0;
		item          = '0;
		words_sent    = 0;
		chars_checked = 0;
		error_count   = 0;
		quiet_left    = 0;
		kind_seen     = '{default: 0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			issue_word(vec_item[i], vec_text[i]);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			w.kind  = random_kind();
			w.value = random_value();
			issue_word(w, "");
		end
		start <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d words: %0d decimal, %0d lower hex, %0d upper hex, %0d kind three",
			words_sent, kind_seen[KIND_DEC], kind_seen[KIND_HEX_LOWER],
			kind_seen[KIND_HEX_UPPER], kind_seen[KIND_HEX_ALT]);
		$display("checked %0d characters, %0d errors", chars_checked, error_count);
		if (error_count == 0)
			$display("integer_to_ascii_formatter_unit_test OK");
		else
			$display("integer_to_ascii_formatter_unit_test NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d characters outstanding", $time, pending_chars.size());
		$display("integer_to_ascii_formatter_unit_test NOT OK");
		$finish;
	end

endmodule
